FILE: rtl/core/ip_address_text_classifier_macros.svh
// ----------------------------------------------------------------------------
// ip_address_text_classifier_macros.svh
// Assertion macros for the address text classifier; empty bodies in synthesis.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_MACROS_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every edge outside reset
`define IPTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iptc assertion failed");

// Property checked at every edge, reset included
`define IPTC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("iptc assertion failed");

`else

`define IPTC_ASSERT(lbl, clk, rst_n, prop)
`define IPTC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/core/iptc_pkg.sv
// ----------------------------------------------------------------------------
// iptc_pkg
// Shared types and constants of the address text classifier.
// ----------------------------------------------------------------------------
package iptc_pkg;

  // Character codes
  parameter logic [7:0] CHAR_DOT     = 8'h2E;
  parameter logic [7:0] CHAR_COLON   = 8'h3A;
  parameter logic [7:0] CHAR_ZERO    = 8'h30;
  parameter logic [7:0] CHAR_NINE    = 8'h39;
  parameter logic [7:0] CHAR_LOWER_A = 8'h61;
  parameter logic [7:0] CHAR_LOWER_F = 8'h66;
  parameter logic [7:0] CHAR_UPPER_A = 8'h41;
  parameter logic [7:0] CHAR_UPPER_F = 8'h46;

  // Dotted-decimal limits
  parameter logic [8:0] V4_GROUP_MAX  = 9'd255;
  parameter logic [8:0] V4_GROUP_SAT  = 9'd256;
  parameter logic [2:0] V4_DIGITS_MAX = 3'd3;
  parameter logic [2:0] V4_DOTS_NEED  = 3'd3;
  parameter logic [2:0] CNT3_SAT      = 3'd7;

  // Colon-hex limits
  parameter logic [3:0] V6_COLONS_MAX = 4'd7;
  parameter logic [3:0] V6_COLONS_SAT = 4'd15;
  parameter logic [2:0] V6_HEX_MAX    = 3'd4;

  // Default depth of the queue between front and back
  parameter int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_V4   = 2'd1,
    VERDICT_V6   = 2'd2
  } verdict_t;

  // Classified character as passed from front to back
  typedef struct packed {
    logic       is_dot;
    logic       is_colon;
    logic       is_dec;
    logic       is_zero;
    logic       is_hex;
    logic [3:0] digit;
    logic       last;
  } char_class_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

FILE: rtl/core/iptc_front.sv
// ----------------------------------------------------------------------------
// iptc_front
// Input handshake and character classification ahead of the queue.
// ----------------------------------------------------------------------------
module iptc_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_character,
  input  logic                  in_last_char,
  input  iptc_pkg::queue_status_t q_status,
  output logic                  push,
  output iptc_pkg::char_class_t push_item
);

  // Stall only while the queue has no room
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Character classes
  always_comb begin
    push_item          = '0;
    push_item.is_dot   = (in_character == iptc_pkg::CHAR_DOT);
    push_item.is_colon = (in_character == iptc_pkg::CHAR_COLON);
    push_item.is_dec   = (in_character >= iptc_pkg::CHAR_ZERO) &&
                         (in_character <= iptc_pkg::CHAR_NINE);
    push_item.is_zero  = (in_character == iptc_pkg::CHAR_ZERO);
    push_item.is_hex   = push_item.is_dec ||
                         ((in_character >= iptc_pkg::CHAR_LOWER_A) &&
                          (in_character <= iptc_pkg::CHAR_LOWER_F)) ||
                         ((in_character >= iptc_pkg::CHAR_UPPER_A) &&
                          (in_character <= iptc_pkg::CHAR_UPPER_F));
    push_item.digit    = in_character[3:0];
    push_item.last     = in_last_char;
  end

endmodule

FILE: rtl/core/iptc_queue.sv
// ----------------------------------------------------------------------------
// iptc_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module iptc_queue #(
  parameter int DEPTH = iptc_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  iptc_pkg::char_class_t   push_item,
  input  logic                    pop,
  output iptc_pkg::queue_status_t status,
  output iptc_pkg::char_class_t   pop_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  iptc_pkg::char_class_t store_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  // Pointer wrap
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = store_r[rd_ptr_r];
  assign status.full  = (count_r == CntW'(DEPTH));
  assign status.valid = (count_r != '0);

endmodule

FILE: rtl/core/iptc_back.sv
// ----------------------------------------------------------------------------
// iptc_back
// Both address checkers and the verdict output register.
// ----------------------------------------------------------------------------
module iptc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iptc_pkg::queue_status_t q_status,
  input  iptc_pkg::char_class_t   q_item,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_verdict
);

  // Dotted-decimal checker state
  logic       v4_failed_r, v4_failed_nxt;
  logic [2:0] v4_dot_count_r, v4_dot_count_nxt;
  logic [8:0] v4_group_value_r, v4_group_value_nxt;
  logic [2:0] v4_digit_count_r, v4_digit_count_nxt;
  logic       v4_leading_zero_r, v4_leading_zero_nxt;
  // Colon-hex checker state
  logic       v6_failed_r, v6_failed_nxt;
  logic [3:0] v6_colon_count_r, v6_colon_count_nxt;
  logic [2:0] v6_hex_count_r, v6_hex_count_nxt;
  logic       v6_empty_seen_r, v6_empty_seen_nxt;
  // Output register
  logic       out_valid_r, out_valid_nxt;
  iptc_pkg::verdict_t out_verdict_r, out_verdict_nxt;

  logic [12:0] v4_mul10;
  logic        v4_ok;
  logic        v6_ok;

  // Take an item unless it ends a string while the output slot is held
  assign pop = q_status.valid && (!q_item.last || !out_valid_r || !out_stall);

  assign v4_mul10 = 13'({v4_group_value_r, 3'b000}) + 13'({v4_group_value_r, 1'b0}) +
                    13'(q_item.digit);

  // Dotted-decimal update
  always_comb begin
    v4_failed_nxt       = v4_failed_r;
    v4_dot_count_nxt    = v4_dot_count_r;
    v4_group_value_nxt  = v4_group_value_r;
    v4_digit_count_nxt  = v4_digit_count_r;
    v4_leading_zero_nxt = 1'b0;
    if (v4_failed_r) begin
      v4_failed_nxt = 1'b1;
    end else if (v4_leading_zero_r && !q_item.is_dot) begin
      v4_failed_nxt = 1'b1;
    end else if (q_item.is_dot) begin
      if ((v4_digit_count_r == '0) || (v4_digit_count_r > iptc_pkg::V4_DIGITS_MAX) ||
          (v4_group_value_r > iptc_pkg::V4_GROUP_MAX)) begin
        v4_failed_nxt = 1'b1;
      end else begin
        if (v4_dot_count_r != iptc_pkg::CNT3_SAT) begin
          v4_dot_count_nxt = v4_dot_count_r + 1'b1;
        end
        v4_group_value_nxt = '0;
        v4_digit_count_nxt = '0;
      end
    end else if (q_item.is_dec) begin
      v4_leading_zero_nxt = (v4_digit_count_r == '0) && q_item.is_zero && !q_item.last;
      if (v4_mul10 > 13'(iptc_pkg::V4_GROUP_SAT)) begin
        v4_group_value_nxt = iptc_pkg::V4_GROUP_SAT;
      end else begin
        v4_group_value_nxt = v4_mul10[8:0];
      end
      if (v4_digit_count_r != iptc_pkg::CNT3_SAT) begin
        v4_digit_count_nxt = v4_digit_count_r + 1'b1;
      end
    end else begin
      v4_failed_nxt = 1'b1;
    end
  end

  // Colon-hex update
  always_comb begin
    v6_failed_nxt      = v6_failed_r;
    v6_colon_count_nxt = v6_colon_count_r;
    v6_hex_count_nxt   = v6_hex_count_r;
    v6_empty_seen_nxt  = v6_empty_seen_r;
    if (!v6_failed_r) begin
      if (q_item.is_colon) begin
        if ((v6_hex_count_r == '0) && v6_empty_seen_r) begin
          v6_failed_nxt = 1'b1;
        end else if (v6_hex_count_r > iptc_pkg::V6_HEX_MAX) begin
          v6_failed_nxt = 1'b1;
        end else begin
          if (v6_hex_count_r == '0) begin
            v6_empty_seen_nxt = 1'b1;
          end
          if (v6_colon_count_r != iptc_pkg::V6_COLONS_SAT) begin
            v6_colon_count_nxt = v6_colon_count_r + 1'b1;
          end
          v6_hex_count_nxt = '0;
        end
      end else if (q_item.is_hex) begin
        if (v6_hex_count_r != iptc_pkg::CNT3_SAT) begin
          v6_hex_count_nxt = v6_hex_count_r + 1'b1;
        end
      end else begin
        v6_failed_nxt = 1'b1;
      end
    end
  end

  // Verdict from the updated state
  assign v4_ok = !v4_failed_nxt && (v4_dot_count_nxt == iptc_pkg::V4_DOTS_NEED) &&
                 (v4_digit_count_nxt != '0) && (v4_group_value_nxt <= iptc_pkg::V4_GROUP_MAX);
  assign v6_ok = !v6_failed_nxt && (v6_colon_count_nxt <= iptc_pkg::V6_COLONS_MAX) &&
                 (v6_hex_count_nxt != '0) && (v6_hex_count_nxt <= iptc_pkg::V6_HEX_MAX);

  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_verdict_nxt = out_verdict_r;
    if (pop && q_item.last) begin
      out_valid_nxt = 1'b1;
      priority if (v4_ok) begin
        out_verdict_nxt = iptc_pkg::VERDICT_V4;
      end else if (v6_ok) begin
        out_verdict_nxt = iptc_pkg::VERDICT_V6;
      end else begin
        out_verdict_nxt = iptc_pkg::VERDICT_NONE;
      end
    end
  end

  // Checker state, cleared at the end of each string, and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_failed_r       <= 1'b0;
      v4_dot_count_r    <= '0;
      v4_group_value_r  <= '0;
      v4_digit_count_r  <= '0;
      v4_leading_zero_r <= 1'b0;
      v6_failed_r       <= 1'b0;
      v6_colon_count_r  <= '0;
      v6_hex_count_r    <= '0;
      v6_empty_seen_r   <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop && q_item.last) begin
        v4_failed_r       <= 1'b0;
        v4_dot_count_r    <= '0;
        v4_group_value_r  <= '0;
        v4_digit_count_r  <= '0;
        v4_leading_zero_r <= 1'b0;
        v6_failed_r       <= 1'b0;
        v6_colon_count_r  <= '0;
        v6_hex_count_r    <= '0;
        v6_empty_seen_r   <= 1'b0;
      end else if (pop) begin
        v4_failed_r       <= v4_failed_nxt;
        v4_dot_count_r    <= v4_dot_count_nxt;
        v4_group_value_r  <= v4_group_value_nxt;
        v4_digit_count_r  <= v4_digit_count_nxt;
        v4_leading_zero_r <= v4_leading_zero_nxt;
        v6_failed_r       <= v6_failed_nxt;
        v6_colon_count_r  <= v6_colon_count_nxt;
        v6_hex_count_r    <= v6_hex_count_nxt;
        v6_empty_seen_r   <= v6_empty_seen_nxt;
      end
    end
  end

  // Verdict payload
  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = 2'(out_verdict_r);

endmodule

FILE: rtl/core/ip_address_text_classifier.sv
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// Classifies an address string, one character per item, as IPv4, IPv6 or
// neither.
// ----------------------------------------------------------------------------
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_character[7:0], in_last_char
//   out      output     out_valid/out_stall out_verdict[1:0]
//
// One character per cycle sustained while the queue has room; the back checkers
// update as each character leaves the queue. The last character is first written
// into the queue, and its verdict and out_valid are registered as it is popped.
// Synchronous active-low reset clears the queue, checkers and output valid.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full; a stalled
// verdict holds back only a following last character.
// ----------------------------------------------------------------------------
`include "ip_address_text_classifier_macros.svh"

module ip_address_text_classifier #(
  parameter int QUEUE_DEPTH = iptc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict
);

  iptc_pkg::queue_status_t q_status;
  iptc_pkg::char_class_t   push_item;
  iptc_pkg::char_class_t   pop_item;
  logic                    push;
  logic                    pop;

  // Front: handshake and classification
  iptc_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .in_last_char (in_last_char),
    .q_status     (q_status),
    .push         (push),
    .push_item    (push_item)
  );

  // Queue between front and back
  iptc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .status    (q_status),
    .pop_item  (pop_item)
  );

  // Back: checkers and verdict
  iptc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_status    (q_status),
    .q_item      (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict)
  );

  // An accepted item is waiting in the queue on the next cycle
  `IPTC_ASSERT(a_push_fills, clk, rst_n, push |=> q_status.valid)
  // A new verdict only follows a popped last character
  `IPTC_ASSERT(a_verdict_src, clk, rst_n, (out_valid && !$past(out_valid)) |-> $past(pop && pop_item.last))
  // A held verdict is never overwritten
  `IPTC_ASSERT(a_no_overrun, clk, rst_n, (out_valid && out_stall) |-> !(pop && pop_item.last))

endmodule
